// File: src/ilog2_pkg.sv
// Shared constants, mode codes and the sixteenths fraction table for the log2 unit.
`timescale 1ns / 1ps

package ilog2_pkg;

	localparam int unsigned OPERAND_W = 32;
	localparam int unsigned MODE_W    = 2;
	localparam int unsigned RESULT_W  = 10;
	localparam int unsigned POS_W     = $clog2(OPERAND_W);

	// Mantissa widths: 17 bits for the sqrt2 rounding test, 8 bits for the table lookup
	localparam int unsigned ROUND_MANT_W = 17;
	localparam int unsigned FRAC_MANT_W  = 8;
	localparam int unsigned FRAC_IDX_W   = FRAC_MANT_W - 1;
	localparam int unsigned FRAC_W       = 5;

	// sqrt(2) * 65536, the rounding point in the log domain
	localparam logic [ROUND_MANT_W-1:0] ROUND_POINT = 17'd92682;

	typedef enum logic [MODE_W-1:0] {
		MODE_FLOOR      = 2'd0,
		MODE_CEIL       = 2'd1,
		MODE_ROUND      = 2'd2,
		MODE_SIXTEENTHS = 2'd3
	} mode_t;

	// round(16 * log2 m) - 112 for m = 128..255, indexed by m - 128
	localparam logic [FRAC_W-1:0] FRAC_ROM [1 << FRAC_IDX_W] = '{
		5'd0,  5'd0,  5'd0,  5'd1,  5'd1,  5'd1,  5'd1,  5'd1,
		5'd1,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd2,  5'd3,
		5'd3,  5'd3,  5'd3,  5'd3,  5'd3,  5'd4,  5'd4,  5'd4,
		5'd4,  5'd4,  5'd4,  5'd4,  5'd5,  5'd5,  5'd5,  5'd5,
		5'd5,  5'd5,  5'd5,  5'd6,  5'd6,  5'd6,  5'd6,  5'd6,
		5'd6,  5'd6,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,  5'd7,
		5'd7,  5'd7,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,  5'd8,
		5'd8,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,  5'd9,
		5'd9,  5'd9,  5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
		5'd10, 5'd10, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11, 5'd11,
		5'd11, 5'd11, 5'd11, 5'd12, 5'd12, 5'd12, 5'd12, 5'd12,
		5'd12, 5'd12, 5'd12, 5'd12, 5'd13, 5'd13, 5'd13, 5'd13,
		5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd13, 5'd14, 5'd14,
		5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14, 5'd14,
		5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15, 5'd15,
		5'd15, 5'd15, 5'd15, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16
	};

endpackage

// File: src/integer_log2_unit.sv
// Integer base-2 logarithm unit: floor, ceiling, sqrt2-rounded and sixteenths modes.
//
// Usage
//   Input channel (in_valid / in_stall) carries mode and operand_value; output channel
//   (out_valid / out_stall) carries log_result. A transfer happens on a rising edge with
//   valid high and stall low. One result leaves for every input transfer, in order.
//   out_valid rises when the result register loads an item from the input register. The
//   operand is captured in the input register, then a leading-one encoder, a normalising
//   left shift, a 128-entry fraction table and one small add feed the result register.
//   Throughput is one transfer per cycle while the receiver does not stall; the encoder
//   and shifter are combinational between the two registers.
//   When the receiver stalls, the result register holds its value and the input register
//   still takes one more transfer; in_stall rises only when both registers are full and
//   out_stall is high.
//   Operands 0 and 1 give 0 in every mode. Mode 3 results are in units of 1/16.
//   Reset (arst_n low, asynchronous) empties both registers; no data is kept.
`timescale 1ns / 1ps

module integer_log2_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ilog2_pkg::MODE_W-1:0]        mode,
	input  logic [ilog2_pkg::OPERAND_W-1:0]     operand_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [ilog2_pkg::RESULT_W-1:0]      log_result
);

	import ilog2_pkg::*;

	logic                     valid_s1;
	mode_t                    mode_s1;
	logic [OPERAND_W-1:0]     value_s1;
	logic                     valid_s2;
	logic [RESULT_W-1:0]      log_result_s2;

	logic                     adv_s2;
	logic                     load_s1;

	logic [POS_W-1:0]         lead_pos;
	logic [OPERAND_W-1:0]     norm_value;
	logic [ROUND_MANT_W-1:0]  round_mant;
	logic [FRAC_MANT_W-1:0]   frac_mant;
	logic [FRAC_W-1:0]        frac_val;
	logic                     pow2;
	logic [RESULT_W-1:0]      floor_ext;
	logic [RESULT_W-1:0]      result_d;

	// Pipeline control: the result register moves when empty or taken
	assign adv_s2   = !valid_s2 || !out_stall;
	assign load_s1  = !valid_s1 || adv_s2;
	assign in_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1)
				valid_s1 <= in_valid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	// Payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			mode_s1  <= mode_t'(mode);
			value_s1 <= operand_value;
		end
		if (adv_s2 && valid_s1)
			log_result_s2 <= result_d;
	end

	// Leading-one position; zero for a zero operand
	always_comb begin
		lead_pos = '0;
		for (int i = 0; i < OPERAND_W; i++) begin
			if (value_s1[i])
				lead_pos = POS_W'(i);
		end
	end

	// Normalise so the leading one sits at the top bit; mantissas are the top bits
	assign norm_value = value_s1 << (POS_W'(OPERAND_W - 1) - lead_pos);
	assign round_mant = norm_value[OPERAND_W-1 -: ROUND_MANT_W];
	assign frac_mant  = norm_value[OPERAND_W-1 -: FRAC_MANT_W];
	assign frac_val   = FRAC_ROM[frac_mant[FRAC_IDX_W-1:0]];
	assign pow2       = (value_s1 & (value_s1 - OPERAND_W'(1))) == '0;
	assign floor_ext  = RESULT_W'(lead_pos);

	// Mode select; operands 0 and 1 give zero
	always_comb begin
		result_d = '0;
		if (value_s1 > OPERAND_W'(1)) begin
			case (mode_s1)
				MODE_FLOOR:
					result_d = floor_ext;
				MODE_CEIL:
					result_d = pow2 ? floor_ext : floor_ext + RESULT_W'(1);
				MODE_ROUND:
					result_d = (round_mant >= ROUND_POINT) ? floor_ext + RESULT_W'(1)
					                                       : floor_ext;
				default:
					result_d = (floor_ext << 4) + RESULT_W'(frac_val);
			endcase
		end
	end

	assign out_valid  = valid_s2;
	assign log_result = log_result_s2;

	// Stall only when both registers hold data and the receiver is holding off
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("in_stall raised without a full, stalled pipeline");

	// A held item in the input register reaches the output on the next edge
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && adv_s2) |=> out_valid)
		else $error("input register item lost on advance");

	// Largest result is 32 * 16
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (log_result <= RESULT_W'(512)))
		else $error("log_result out of range");

endmodule

// File: sim/tb_integer_log2_unit.sv
// Self-checking testbench for the integer log2 unit: edges, back-pressure, random operands.
`timescale 1ns / 1ps

module tb_integer_log2_unit;
	import ilog2_pkg::*;

	// Quiet cycles allowed before the run is declared hung
	localparam int unsigned QUIET_LIMIT = 2000;
	// sqrt(2) * 65536: a 17-bit mantissa at or above this rounds the log up
	localparam int unsigned SQRT2_MANT = 92682;
	// Mantissa indexes (m - 128) at which round(16 * log2 m) steps up by one
	localparam int unsigned FRAC_STEPS [16] = '{
		3, 9, 15, 21, 28, 35, 42, 50, 57, 66, 74, 83, 92, 102, 112, 123
	};

	typedef struct {
		mode_t                 mode;
		logic [OPERAND_W-1:0]  operand;
		logic [RESULT_W-1:0]   log_value;
	} log_expect_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [MODE_W-1:0]     mode = '0;
	logic [OPERAND_W-1:0]  operand_value = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [RESULT_W-1:0]   log_result;

	log_expect_t pending_logs [$];
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;
	int unsigned tx_idle_pct = 0;
	int unsigned rx_stall_pct = 0;
	int unsigned rx_hold_request = 0;
	int unsigned rx_hold_left = 0;

	integer_log2_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.operand_value(operand_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.log_result   (log_result)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Expected log2 of one operand in the given mode
	function automatic logic [RESULT_W-1:0] predict_log2(input mode_t md,
			input logic [OPERAND_W-1:0] v);
		int unsigned msb;
		int unsigned frac;
		logic [31:0] mant;
		logic [RESULT_W-1:0] res;
		res = '0;
		if (v > 1) begin
			msb = 0;
			for (int b = 0; b < OPERAND_W; b++)
				if (v[b]) msb = b;
			case (md)
				MODE_FLOOR: res = RESULT_W'(msb);
				MODE_CEIL: res = ((v & (v - 1)) != 0) ? RESULT_W'(msb + 1) : RESULT_W'(msb);
				MODE_ROUND: begin
					// leading one to bit 16; large operands lose their low bits
					mant = (msb >= 16) ? v >> (msb - 16) : v << (16 - msb);
					res = (mant >= SQRT2_MANT) ? RESULT_W'(msb + 1) : RESULT_W'(msb);
				end
				default: begin
					// leading one to bit 7, fraction from the step points
					mant = (msb >= 7) ? v >> (msb - 7) : v << (7 - msb);
					frac = 0;
					foreach (FRAC_STEPS[i])
						if (mant[6:0] >= FRAC_STEPS[i]) frac++;
					res = RESULT_W'(msb * 16 + frac);
				end
			endcase
		end
		return res;
	endfunction

	// Operands spread over every leading-one position, with boundaries favoured
	function automatic logic [OPERAND_W-1:0] pick_operand();
		int unsigned kind;
		int unsigned sh;
		logic [OPERAND_W-1:0] v;
		kind = $urandom_range(9);
		sh = $urandom_range(31);
		case (kind)
			0, 9: v = $urandom;
			1, 2, 3: v = ($urandom | 32'h8000_0000) >> (31 - sh);
			4: v = 32'd1 << sh;
			5: v = (32'd1 << sh) + $urandom_range(2) - 1;
			6: begin
				// around the sqrt2 rounding point
				if (sh >= 16)
					v = (32'(92680 + $urandom_range(4)) << (sh - 16))
						| ($urandom & ((32'd1 << (sh - 16)) - 1));
				else
					v = (SQRT2_MANT >> (16 - sh)) + $urandom_range(2) - 1;
			end
			7: begin
				// on a fraction step point for the sixteenths table
				if (sh >= 7)
					v = (32'(128 + FRAC_STEPS[$urandom_range(15)] - $urandom_range(1))
						<< (sh - 7)) | ($urandom & ((32'd1 << (sh - 7)) - 1));
				else
					v = $urandom_range(255);
			end
			default: v = $urandom_range(3);
		endcase
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatch_count++;
	endtask

	// Offer one operand, with a random gap first, and hold it until transfer
	task automatic send_operand(input mode_t md, input logic [OPERAND_W-1:0] v);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			operand_value <= $urandom;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		mode <= md;
		operand_value <= v;
		do @(posedge clk); while (in_stall);
	endtask

	// One edge first so the last transfer is already queued
	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_logs.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed_edges();
		mode_t md;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		// zero and one give zero; the largest word in every mode
		for (int m = 0; m < 4; m++) begin
			md = mode_t'(m);
			send_operand(md, 32'd0);
			send_operand(md, 32'd1);
			send_operand(md, 32'hFFFF_FFFF);
		end
		// largest ceiling, round point either side, table ends
		send_operand(MODE_CEIL, 32'h8000_0000);
		send_operand(MODE_CEIL, 32'h8000_0001);
		send_operand(MODE_ROUND, 32'd92682);
		send_operand(MODE_ROUND, 32'd92681);
		send_operand(MODE_ROUND, 32'd3);
		send_operand(MODE_ROUND, 32'hB504_F000);
		send_operand(MODE_SIXTEENTHS, 32'd2);
		send_operand(MODE_SIXTEENTHS, 32'd255);
		send_operand(MODE_SIXTEENTHS, 32'h8000_0000);
		send_operand(MODE_FLOOR, 32'd2);
		pause_until_drained();
	endtask

	// Receiver holds off long enough for the unit to fill and stall its input
	task automatic test_output_hold_off();
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		rx_hold_request = 60;
		repeat (24) send_operand(mode_t'($urandom_range(3)), pick_operand());
		pause_until_drained();
	endtask

	task automatic test_random_operands(input int unsigned count, input int unsigned tx_pct,
			input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_stall_pct = rx_pct;
		repeat (count) send_operand(mode_t'($urandom_range(3)), pick_operand());
		pause_until_drained();
	endtask

	// Receiver stall: random, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (rx_hold_request != 0) begin
			rx_hold_left = rx_hold_request;
			rx_hold_request = 0;
		end
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// Expectations on input transfers, checks on output transfers, hang watchdog
	always @(posedge clk) begin
		log_expect_t exp_log;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				exp_log.mode = mode_t'(mode);
				exp_log.operand = operand_value;
				exp_log.log_value = predict_log2(mode_t'(mode), operand_value);
				pending_logs.push_back(exp_log);
			end
			if (out_valid && !out_stall) begin
				if (pending_logs.size() == 0) begin
					report_mismatch($sformatf("result %0d with nothing expected", log_result));
				end else begin
					exp_log = pending_logs.pop_front();
					if (log_result !== exp_log.log_value)
						report_mismatch($sformatf("mode %s operand %h: log_result %0d, want %0d",
							exp_log.mode.name(), exp_log.operand, log_result,
							exp_log.log_value));
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_edges();
		test_output_hold_off();
		test_random_operands(300, 0, 0);
		test_random_operands(300, 55, 0);
		test_random_operands(300, 0, 55);
		test_random_operands(300, 8, 8);
		repeat (8) @(posedge clk);
		if (pending_logs.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_logs.size()));
		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
